// ===== hdl/vppd_pkg.sv =====
// shared types, constants and a saturation helper for the vertex projection block
package vppd_pkg;

  localparam int unsigned NumRows   = 4;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned DataW     = 32;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned ProdW     = CoefW + DataW;        // one coefficient product
  localparam int unsigned AccW      = ProdW + 2;            // sum of three products plus translation
  localparam int unsigned QuoW      = DataW + 1;            // reciprocal quotient bits
  localparam int unsigned DivStages = QuoW;                 // one quotient bit per stage
  localparam int unsigned Latency   = 5 + DivStages + 3;    // start to done

  localparam logic [CfgW-1:0] RowXRst = 64'h0000_0000_0000_1000;
  localparam logic [CfgW-1:0] RowYRst = 64'h0000_0000_1000_0000;
  localparam logic [CfgW-1:0] RowZRst = 64'h0000_1000_0000_0000;
  localparam logic [CfgW-1:0] RowWRst = 64'h1000_0000_0000_0000;

  localparam logic [DataW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SatNeg = 32'h8000_0000;

  typedef enum logic [1:0] {
    ROW_X = 2'd0,
    ROW_Y = 2'd1,
    ROW_Z = 2'd2,
    ROW_W = 2'd3
  } row_idx_e;

  // values that ride alongside the reciprocal divider
  typedef struct packed {
    logic                  w_zero;
    logic                  neg_w;
    logic [DataW-1:0]      clip_w;
    logic [2:0][DataW-1:0] mag_c;
    logic [2:0]            sgn_c;
  } side_t;

  // apply sign to a rounded magnitude and clamp to signed 32 bits
  function automatic logic [DataW-1:0] sat32(input logic neg, input logic [63:0] q);
    logic [DataW-1:0] res;
    if (neg) begin
      res = (q >= 64'h8000_0000) ? SatNeg : (~q[DataW-1:0] + 32'd1);
    end else begin
      res = (q > 64'h7FFF_FFFF) ? SatPos : q[DataW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/vertex_project_perspective_divide.sv =====
// top level: matrix transform, pipelined reciprocal and perspective scale
//
// Fully pipelined vertex transform: one vertex beat may be started every clock and busy_o
// is never raised. Each beat returns exactly one result, shown for one cycle with done_o,
// once it has passed 5 transform stages, 33 reciprocal stages at one quotient bit each and
// 3 scale stages. The receiver cannot stall, so results must be taken as they appear.
// Matrix rows are written through the cfg port; write them only while no beat is in flight.
// Arithmetic is signed Q16.16 for positions and results, Q4.12 for coefficients, with
// round-half-away rounding and saturation; a clip w of zero zeroes the ndc, recip_w and
// clip_w outputs and raises w_zero_o.
module vertex_project_perspective_divide (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [vppd_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [vppd_pkg::DataW-1:0] pos_x_i,
  input  logic signed [vppd_pkg::DataW-1:0] pos_y_i,
  input  logic signed [vppd_pkg::DataW-1:0] pos_z_i,
  output logic                          done_o,
  output logic signed [vppd_pkg::DataW-1:0] ndc_x_o,
  output logic signed [vppd_pkg::DataW-1:0] ndc_y_o,
  output logic signed [vppd_pkg::DataW-1:0] ndc_z_o,
  output logic signed [vppd_pkg::DataW-1:0] clip_w_out_o,
  output logic signed [vppd_pkg::DataW-1:0] recip_w_o,
  output logic                          w_zero_o
);

  localparam int unsigned DW = vppd_pkg::DataW;
  localparam int unsigned PW = vppd_pkg::ProdW;
  localparam int unsigned AW = vppd_pkg::AccW;
  localparam int unsigned QW = vppd_pkg::QuoW;
  localparam int unsigned NS = vppd_pkg::DivStages;

  // matrix row registers
  logic [vppd_pkg::CfgW-1:0] rows_q [vppd_pkg::NumRows];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= vppd_pkg::RowXRst;
      rows_q[1] <= vppd_pkg::RowYRst;
      rows_q[2] <= vppd_pkg::RowZRst;
      rows_q[3] <= vppd_pkg::RowWRst;
    end else if (cfg_we_i) begin
      unique case (vppd_pkg::row_idx_e'(cfg_idx_i))
        vppd_pkg::ROW_X: rows_q[0] <= cfg_wdata_i;
        vppd_pkg::ROW_Y: rows_q[1] <= cfg_wdata_i;
        vppd_pkg::ROW_Z: rows_q[2] <= cfg_wdata_i;
        vppd_pkg::ROW_W: rows_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline never backs up
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // valid bits for the transform, divider and scale stages
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s7_vld_q, s8_vld_q, done_q;
  logic div_vld_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      done_q   <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        div_vld_q[k] <= 1'b0;
      end
    end else begin
      s1_vld_q     <= accept;
      s2_vld_q     <= s1_vld_q;
      s3_vld_q     <= s2_vld_q;
      s4_vld_q     <= s3_vld_q;
      div_vld_q[0] <= s4_vld_q;
      for (int k = 0; k < NS; k++) begin
        div_vld_q[k+1] <= div_vld_q[k];
      end
      s7_vld_q     <= div_vld_q[NS];
      s8_vld_q     <= s7_vld_q;
      done_q       <= s8_vld_q;
    end
  end

  // stage 1: twelve coefficient products, translations held aside
  logic signed [PW-1:0]    prod_q [4][3];
  logic signed [15:0]      trans_q [4];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      prod_q[r][0] <= $signed(rows_q[r][15:0])  * pos_x_i;
      prod_q[r][1] <= $signed(rows_q[r][31:16]) * pos_y_i;
      prod_q[r][2] <= $signed(rows_q[r][47:32]) * pos_z_i;
      trans_q[r]   <= $signed(rows_q[r][63:48]);
    end
  end

  // stage 2: row sums in Q22.28
  logic signed [AW-1:0] acc_q [4];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      acc_q[r] <= AW'(prod_q[r][0]) + AW'(prod_q[r][1]) + AW'(prod_q[r][2])
                + (AW'(trans_q[r]) <<< 16);
    end
  end

  // stage 3: sign and magnitude
  logic          neg3_q [4];
  logic [AW-1:0] mag3_q [4];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      neg3_q[r] <= acc_q[r][AW-1];
      mag3_q[r] <= acc_q[r][AW-1] ? (~acc_q[r] + AW'(1)) : acc_q[r];
    end
  end

  // stage 4: round to Q16.16 and saturate
  logic [DW-1:0] clip_q [4];
  logic [AW:0]   rnd4 [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rnd4[r] = {1'b0, mag3_q[r]} + (AW+1)'(2048);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      clip_q[r] <= vppd_pkg::sat32(neg3_q[r], 64'(rnd4[r][AW:12]));
    end
  end

  // stage 5: divider load, numerator 2^32 + |w|/2
  vppd_pkg::side_t side_q [NS+1];
  logic [QW-1:0]   nq_q   [NS+1];
  logic [DW-1:0]   rem_q  [NS+1];
  logic [DW-1:0]   dvs_q  [NS+1];
  logic [DW-1:0]   mag_w;

  assign mag_w = clip_q[3][DW-1] ? (~clip_q[3] + DW'(1)) : clip_q[3];

  always_ff @(posedge clk_i) begin
    side_q[0].w_zero <= (clip_q[3] == '0);
    side_q[0].neg_w  <= clip_q[3][DW-1];
    side_q[0].clip_w <= clip_q[3];
    for (int i = 0; i < 3; i++) begin
      side_q[0].sgn_c[i] <= clip_q[i][DW-1];
      side_q[0].mag_c[i] <= clip_q[i][DW-1] ? (~clip_q[i] + DW'(1)) : clip_q[i];
    end
    nq_q[0]  <= {1'b1, {DW{1'b0}}} + QW'(mag_w >> 1);
    rem_q[0] <= '0;
    dvs_q[0] <= mag_w;
  end

  // restoring divider, one quotient bit per stage; quotient shifts in under the numerator
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [DW:0] shifted;
    logic        fits;

    assign shifted = {rem_q[k], nq_q[k][QW-1]};
    assign fits    = (shifted >= {1'b0, dvs_q[k]});

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= fits ? DW'(shifted - {1'b0, dvs_q[k]}) : DW'(shifted);
      nq_q[k+1]   <= {nq_q[k][QW-2:0], fits};
      dvs_q[k+1]  <= dvs_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  // stage 7: signed, saturated reciprocal and its magnitude
  logic [QW-1:0]   quo;
  logic [DW-1:0]   recip7_q;
  logic [DW-1:0]   magr7_q;
  vppd_pkg::side_t side7_q;

  assign quo = nq_q[NS];

  always_ff @(posedge clk_i) begin
    side7_q <= side_q[NS];
    if (side_q[NS].neg_w) begin
      recip7_q <= vppd_pkg::sat32(1'b1, 64'(quo));
      magr7_q  <= (quo >= QW'(33'h0_8000_0000)) ? vppd_pkg::SatNeg : quo[DW-1:0];
    end else begin
      recip7_q <= vppd_pkg::sat32(1'b0, 64'(quo));
      magr7_q  <= (quo > QW'(33'h0_7FFF_FFFF)) ? vppd_pkg::SatPos : quo[DW-1:0];
    end
  end

  // stage 8: scale the three clip magnitudes
  logic [2*DW-1:0] scl8_q [3];
  logic            neg8_q [3];
  logic [DW-1:0]   recip8_q;
  vppd_pkg::side_t side8_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      scl8_q[i] <= side7_q.mag_c[i] * magr7_q;
      neg8_q[i] <= side7_q.sgn_c[i] ^ side7_q.neg_w;
    end
    recip8_q <= recip7_q;
    side8_q  <= side7_q;
  end

  // stage 9: round to Q16.16, saturate, zero-w override
  logic [2*DW:0] rnd9 [3];
  logic [DW-1:0] ndc_q [3];
  logic [DW-1:0] clipw_q, recip_q;
  logic          wz_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd9[i] = {1'b0, scl8_q[i]} + (2*DW+1)'(32768);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ndc_q[i] <= side8_q.w_zero ? '0 : vppd_pkg::sat32(neg8_q[i], 64'(rnd9[i][2*DW:16]));
    end
    clipw_q <= side8_q.w_zero ? '0 : side8_q.clip_w;
    recip_q <= side8_q.w_zero ? '0 : recip8_q;
    wz_q    <= side8_q.w_zero;
  end

  assign done_o       = done_q;
  assign ndc_x_o      = ndc_q[0];
  assign ndc_y_o      = ndc_q[1];
  assign ndc_z_o      = ndc_q[2];
  assign clip_w_out_o = clipw_q;
  assign recip_w_o    = recip_q;
  assign w_zero_o     = wz_q;

  // every result traces back to a start a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, vppd_pkg::Latency))
    else $error("result without matching start");

  // zero w clears reciprocal, clip w and ndc x
  a_wzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && w_zero_o |-> recip_w_o == '0 && clip_w_out_o == '0 && ndc_x_o == '0)
    else $error("zero w result not cleared");

  // reciprocal keeps the sign of clip w and is nonzero
  a_rsign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !w_zero_o |-> recip_w_o[31] == clip_w_out_o[31] && recip_w_o != '0)
    else $error("reciprocal sign mismatch");

endmodule
